### hdl/rfpw_pkg.sv
// Shared constants, types and helpers of the pulse-width remote decoder.
package rfpw_pkg;

  localparam int CODE_BITS_DEF  = 40;
  localparam int SLOT_COUNT_DEF = 16;

  localparam int WIDTH_W  = 16;
  localparam int CODE_W   = 40;
  localparam int SLOT_W   = 4;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 5;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_SYNC_MIN = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SYNC_MAX = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ZERO_MIN = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ZERO_MAX = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ONE_MIN  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ONE_MAX  = 3'd5;

  localparam logic [WIDTH_W-1:0] SYNC_MIN_RST = 16'd400;
  localparam logic [WIDTH_W-1:0] SYNC_MAX_RST = 16'd600;
  localparam logic [WIDTH_W-1:0] ZERO_MIN_RST = 16'd20;
  localparam logic [WIDTH_W-1:0] ZERO_MAX_RST = 16'd40;
  localparam logic [WIDTH_W-1:0] ONE_MIN_RST  = 16'd60;
  localparam logic [WIDTH_W-1:0] ONE_MAX_RST  = 16'd80;

  typedef struct packed {
    logic [WIDTH_W-1:0] sync_min;
    logic [WIDTH_W-1:0] sync_max;
    logic [WIDTH_W-1:0] zero_min;
    logic [WIDTH_W-1:0] zero_max;
    logic [WIDTH_W-1:0] one_min;
    logic [WIDTH_W-1:0] one_max;
  } bounds_t;

  typedef struct packed {
    logic sync_hit;
    logic bit_hit;
    logic one_hit;
  } pulse_class_t;

  // Both bounds are exclusive.
  function automatic logic in_window(input logic [WIDTH_W-1:0] w,
                                     input logic [WIDTH_W-1:0] lo,
                                     input logic [WIDTH_W-1:0] hi);
    in_window = (w > lo) && (w < hi);
  endfunction

endpackage

### hdl/rf_remote_pulse_width_decoder.sv
// Top level of the pulse-width coded remote receiver with its register port.
// A result is registered once its final pulse has passed the input register.
// Throughput: one pulse per cycle, set by the input register feeding the
// decode logic and the result register; a stalled result holds a full input
// register, which then holds in_ready low until the result is taken.
// Reset (rst, synchronous) clears reception, bit count, slot counter and
// valids, and loads the default window bounds.
module rf_remote_pulse_width_decoder #(
  parameter int CODE_BITS  = rfpw_pkg::CODE_BITS_DEF,
  parameter int SLOT_COUNT = rfpw_pkg::SLOT_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rfpw_pkg::WIDTH_W-1:0]  pulse_width,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rfpw_pkg::CODE_W-1:0]   code,
  output logic [rfpw_pkg::SLOT_W-1:0]   slot,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rfpw_pkg::ADDR_W-1:0]   paddr,
  input  logic [rfpw_pkg::DATA_W-1:0]   pwdata,
  output logic [rfpw_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int CNT_W  = $clog2(CODE_BITS + 1);
  localparam int SCNT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [CNT_W-1:0]  LAST_BIT  = CNT_W'(CODE_BITS - 1);
  localparam logic [SCNT_W-1:0] LAST_SLOT = SCNT_W'(SLOT_COUNT - 1);

  rfpw_pkg::bounds_t bounds;
  logic [rfpw_pkg::REG_IDX_W-1:0] reg_idx;
  logic cfg_write;

  // Register port
  assign pready    = 1'b1;
  assign reg_idx   = paddr[rfpw_pkg::ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      bounds.sync_min <= rfpw_pkg::SYNC_MIN_RST;
      bounds.sync_max <= rfpw_pkg::SYNC_MAX_RST;
      bounds.zero_min <= rfpw_pkg::ZERO_MIN_RST;
      bounds.zero_max <= rfpw_pkg::ZERO_MAX_RST;
      bounds.one_min  <= rfpw_pkg::ONE_MIN_RST;
      bounds.one_max  <= rfpw_pkg::ONE_MAX_RST;
    end else if (cfg_write) begin
      case (reg_idx)
        rfpw_pkg::REG_SYNC_MIN: bounds.sync_min <= pwdata[rfpw_pkg::WIDTH_W-1:0];
        rfpw_pkg::REG_SYNC_MAX: bounds.sync_max <= pwdata[rfpw_pkg::WIDTH_W-1:0];
        rfpw_pkg::REG_ZERO_MIN: bounds.zero_min <= pwdata[rfpw_pkg::WIDTH_W-1:0];
        rfpw_pkg::REG_ZERO_MAX: bounds.zero_max <= pwdata[rfpw_pkg::WIDTH_W-1:0];
        rfpw_pkg::REG_ONE_MIN:  bounds.one_min  <= pwdata[rfpw_pkg::WIDTH_W-1:0];
        rfpw_pkg::REG_ONE_MAX:  bounds.one_max  <= pwdata[rfpw_pkg::WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      rfpw_pkg::REG_SYNC_MIN: prdata[rfpw_pkg::WIDTH_W-1:0] = bounds.sync_min;
      rfpw_pkg::REG_SYNC_MAX: prdata[rfpw_pkg::WIDTH_W-1:0] = bounds.sync_max;
      rfpw_pkg::REG_ZERO_MIN: prdata[rfpw_pkg::WIDTH_W-1:0] = bounds.zero_min;
      rfpw_pkg::REG_ZERO_MAX: prdata[rfpw_pkg::WIDTH_W-1:0] = bounds.zero_max;
      rfpw_pkg::REG_ONE_MIN:  prdata[rfpw_pkg::WIDTH_W-1:0] = bounds.one_min;
      rfpw_pkg::REG_ONE_MAX:  prdata[rfpw_pkg::WIDTH_W-1:0] = bounds.one_max;
      default: prdata = '0;
    endcase
  end

  // Input register
  logic                         s1_valid;
  logic [rfpw_pkg::WIDTH_W-1:0] s1_width;
  logic                         s1_fire;

  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_width <= pulse_width;
    end
  end

  // Decode
  rfpw_pkg::pulse_class_t pclass;

  rfpw_classify u_classify (
    .pulse_width (s1_width),
    .bounds      (bounds),
    .pclass      (pclass)
  );

  logic                 receiving;
  logic                 receiving_next;
  logic [CNT_W-1:0]     bit_count;
  logic [CNT_W-1:0]     bit_count_next;
  logic [CODE_BITS-1:0] shift_word;
  logic [CODE_BITS-1:0] shift_word_next;
  logic [SCNT_W-1:0]    slot_counter;
  logic [SCNT_W-1:0]    slot_counter_next;
  logic                 emit;

  always_comb begin
    receiving_next    = receiving;
    bit_count_next    = bit_count;
    shift_word_next   = shift_word;
    slot_counter_next = slot_counter;
    emit              = 1'b0;
    if (pclass.sync_hit) begin
      receiving_next  = 1'b1;
      bit_count_next  = '0;
      shift_word_next = '0;
    end else if (receiving && pclass.bit_hit) begin
      shift_word_next = {shift_word[CODE_BITS-2:0], pclass.one_hit};
      if (bit_count == LAST_BIT) begin
        emit              = 1'b1;
        receiving_next    = 1'b0;
        bit_count_next    = '0;
        slot_counter_next = (slot_counter == LAST_SLOT) ? '0 : slot_counter + 1'b1;
      end else begin
        bit_count_next = bit_count + 1'b1;
      end
    end else begin
      receiving_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      receiving    <= 1'b0;
      bit_count    <= '0;
      shift_word   <= '0;
      slot_counter <= '0;
    end else if (s1_fire) begin
      receiving    <= receiving_next;
      bit_count    <= bit_count_next;
      shift_word   <= shift_word_next;
      slot_counter <= slot_counter_next;
    end
  end

  // Result register
  logic [CODE_BITS+rfpw_pkg::CODE_W-1:0] code_ext;
  logic [SCNT_W+rfpw_pkg::SLOT_W-1:0]    slot_ext;

  assign code_ext = {{rfpw_pkg::CODE_W{1'b0}}, shift_word_next};
  assign slot_ext = {{rfpw_pkg::SLOT_W{1'b0}}, slot_counter};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      code <= code_ext[rfpw_pkg::CODE_W-1:0];
      slot <= slot_ext[rfpw_pkg::SLOT_W-1:0];
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    bit_count <= LAST_BIT)
    else $error("bit count beyond code length");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    slot_counter <= LAST_SLOT)
    else $error("slot counter beyond slot count");

  a_emit_stops: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && emit) |=> (!receiving && bit_count == '0 && out_valid))
    else $error("reception did not stop after a complete code");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while the decode stage is stalled");
`endif

endmodule

### hdl/rfpw_classify.sv
// Sorts one pulse width into sync, zero-bit and one-bit windows.
module rfpw_classify (
  input  logic [rfpw_pkg::WIDTH_W-1:0] pulse_width,
  input  rfpw_pkg::bounds_t            bounds,
  output rfpw_pkg::pulse_class_t       pclass
);

  logic zero_hit;
  logic one_hit;

  assign zero_hit = rfpw_pkg::in_window(pulse_width, bounds.zero_min, bounds.zero_max);
  assign one_hit  = rfpw_pkg::in_window(pulse_width, bounds.one_min, bounds.one_max);

  assign pclass.sync_hit = rfpw_pkg::in_window(pulse_width, bounds.sync_min, bounds.sync_max);
  assign pclass.bit_hit  = zero_hit || one_hit;
  // A width inside both bit windows counts as a one.
  assign pclass.one_hit  = one_hit;

endmodule
